@@ rtl/uprbg_pkg.sv @@
// shared types, register indexes, phase codes and defaults for the ranging bar graph
package uprbg_pkg;

    localparam int TIMER_BITS_DEF = 20;
    localparam int WIDTH_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_WIDTH    = 3'd4;

    localparam logic [7:0]  SETTLE_WIDTH_RST  = 8'd2;
    localparam logic [7:0]  TRIGGER_WIDTH_RST = 8'd10;
    localparam logic [15:0] ECHO_TIMEOUT_RST  = 16'd30000;
    localparam logic [19:0] PAUSE_LENGTH_RST  = 20'd300000;
    localparam logic [13:0] STEP_WIDTH_RST    = 14'd580;

    localparam logic [2:0] PH_SETTLE    = 3'd0;
    localparam logic [2:0] PH_TRIGGER   = 3'd1;
    localparam logic [2:0] PH_WAIT_RISE = 3'd2;
    localparam logic [2:0] PH_MEASURE   = 3'd3;
    localparam logic [2:0] PH_PAUSE     = 3'd4;

    localparam logic [3:0] BAR_ALL_ON  = 4'h0;
    localparam logic [3:0] BAR_ONE     = 4'h8;
    localparam logic [3:0] BAR_TWO     = 4'hC;
    localparam logic [3:0] BAR_THREE   = 4'hE;
    localparam logic [3:0] BAR_ALL_OFF = 4'hF;

    typedef struct packed {
        logic [7:0]  settle_width;
        logic [7:0]  trigger_width;
        logic [15:0] echo_timeout;
        logic [19:0] pause_length;
        logic [13:0] step_width;
    } cfg_t;

    typedef struct packed {
        logic        pin_drive;
        logic        pin_output_enable;
        logic [3:0]  led_bar_n;
        logic        sample_valid;
        logic [15:0] pulse_width_us;
        logic        timed_out;
    } res_t;

endpackage

@@ rtl/uprbg_cfg.sv @@
// configuration register file
module uprbg_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [uprbg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uprbg_pkg::CFG_DATA_W-1:0] cfg_data,
    output uprbg_pkg::cfg_t                  cfg
);
    import uprbg_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_width  <= SETTLE_WIDTH_RST;
            cfg_reg.trigger_width <= TRIGGER_WIDTH_RST;
            cfg_reg.echo_timeout  <= ECHO_TIMEOUT_RST;
            cfg_reg.pause_length  <= PAUSE_LENGTH_RST;
            cfg_reg.step_width    <= STEP_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SETTLE_WIDTH:  cfg_reg.settle_width  <= cfg_data[7:0];
                REG_TRIGGER_WIDTH: cfg_reg.trigger_width <= cfg_data[7:0];
                REG_ECHO_TIMEOUT:  cfg_reg.echo_timeout  <= cfg_data[15:0];
                REG_PAUSE_LENGTH:  cfg_reg.pause_length  <= cfg_data[19:0];
                REG_STEP_WIDTH:    cfg_reg.step_width    <= cfg_data[13:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/uprbg_bar.sv @@
// pulse width to bar graph pattern by comparison against step multiples
module uprbg_bar #(
    parameter int WIDTH_BITS = uprbg_pkg::WIDTH_BITS_DEF
) (
    input  logic [WIDTH_BITS-1:0] width,
    input  logic [13:0]           step_width,
    output logic [3:0]            pattern
);
    import uprbg_pkg::*;

    localparam int CMP_W = (WIDTH_BITS > 16) ? WIDTH_BITS : 16;

    logic [13:0]      s1;
    logic [15:0]      s3;
    logic [CMP_W-1:0] w_ext;
    logic [CMP_W-1:0] m1;
    logic [CMP_W-1:0] m2;
    logic [CMP_W-1:0] m3;
    logic [CMP_W-1:0] m4;

    always_comb
    begin
        s1    = (step_width == 14'd0) ? 14'd1 : step_width;
        s3    = {1'b0, s1, 1'b0} + {2'b00, s1};
        w_ext = CMP_W'(width);
        m1    = CMP_W'(s1);
        m2    = CMP_W'({s1, 1'b0});
        m3    = CMP_W'(s3);
        m4    = CMP_W'({s1, 2'b00});
        priority if (w_ext >= m4)
            pattern = BAR_ALL_OFF;
        else if (w_ext >= m3)
            pattern = BAR_THREE;
        else if (w_ext >= m2)
            pattern = BAR_TWO;
        else if (w_ext >= m1)
            pattern = BAR_ONE;
        else
            pattern = BAR_ALL_ON;
    end

endmodule

@@ rtl/uprbg_ctrl.sv @@
// trigger, echo timing and pause sequencer with measurement result state
module uprbg_ctrl #(
    parameter int TIMER_BITS = uprbg_pkg::TIMER_BITS_DEF,
    parameter int WIDTH_BITS = uprbg_pkg::WIDTH_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            echo,
    input  uprbg_pkg::cfg_t cfg,
    output uprbg_pkg::res_t res
);
    import uprbg_pkg::*;

    localparam int PT_W  = (TIMER_BITS > 20) ? TIMER_BITS : 20;
    localparam int CMP_W = (WIDTH_BITS > 16) ? WIDTH_BITS : 16;

    logic [2:0]            phase_reg,  phase_next;
    logic [TIMER_BITS-1:0] timer_reg,  timer_next;
    logic [WIDTH_BITS-1:0] wcnt_reg,   wcnt_next;
    logic [3:0]            led_reg,    led_next;
    logic [WIDTH_BITS-1:0] lwidth_reg, lwidth_next;
    logic                  lto_reg,    lto_next;

    logic [2:0]            ph;
    logic [TIMER_BITS-1:0] tmr;
    logic [TIMER_BITS-1:0] tmr_inc;
    logic [WIDTH_BITS-1:0] e;
    logic [CMP_W-1:0]      e_ext;
    logic [CMP_W-1:0]      lw_ext;
    logic [7:0]            tw;
    logic [3:0]            bar_pat;
    logic                  drive;
    logic                  oe;
    logic                  valid;

    uprbg_bar #(
        .WIDTH_BITS(WIDTH_BITS)
    ) u_bar (
        .width      (e),
        .step_width (cfg.step_width),
        .pattern    (bar_pat)
    );

    always_comb
    begin
        ph = phase_reg;
        tmr = timer_reg;
        if (ph > PH_PAUSE)
        begin
            ph  = PH_SETTLE;
            tmr = '0;
        end
        if (ph == PH_PAUSE && cfg.pause_length == 20'd0)
        begin
            ph  = PH_SETTLE;
            tmr = '0;
        end
        if (ph == PH_SETTLE && cfg.settle_width == 8'd0)
        begin
            ph  = PH_TRIGGER;
            tmr = '0;
        end
        tmr_inc = (tmr == '1) ? tmr : tmr + TIMER_BITS'(1);
        tw      = (cfg.trigger_width == 8'd0) ? 8'd1 : cfg.trigger_width;
        e       = (wcnt_reg == '1) ? wcnt_reg : wcnt_reg + WIDTH_BITS'(1);
        e_ext   = CMP_W'(e);

        phase_next  = ph;
        timer_next  = tmr;
        wcnt_next   = wcnt_reg;
        led_next    = led_reg;
        lwidth_next = lwidth_reg;
        lto_next    = lto_reg;
        drive       = 1'b0;
        oe          = 1'b0;
        valid       = 1'b0;

        unique case (ph)
            PH_SETTLE:
            begin
                oe         = 1'b1;
                timer_next = tmr_inc;
                if (tmr_inc >= TIMER_BITS'(cfg.settle_width))
                begin
                    phase_next = PH_TRIGGER;
                    timer_next = '0;
                end
            end
            PH_TRIGGER:
            begin
                oe         = 1'b1;
                drive      = 1'b1;
                timer_next = tmr_inc;
                if (tmr_inc >= TIMER_BITS'(tw))
                begin
                    phase_next = PH_WAIT_RISE;
                    timer_next = '0;
                end
            end
            PH_WAIT_RISE:
            begin
                if (echo)
                begin
                    phase_next = PH_MEASURE;
                    wcnt_next  = '0;
                    timer_next = '0;
                end
                else if (tmr > TIMER_BITS'(cfg.echo_timeout))
                begin
                    valid       = 1'b1;
                    lto_next    = 1'b1;
                    lwidth_next = '0;
                    led_next    = BAR_ALL_ON;
                    phase_next  = PH_PAUSE;
                    timer_next  = '0;
                end
                else
                begin
                    timer_next = tmr_inc;
                end
            end
            PH_MEASURE:
            begin
                wcnt_next = e;
                if (!echo)
                begin
                    valid       = 1'b1;
                    lto_next    = 1'b0;
                    lwidth_next = e;
                    led_next    = bar_pat;
                    phase_next  = PH_PAUSE;
                    timer_next  = '0;
                end
                else if (e_ext > CMP_W'(cfg.echo_timeout) || e == '1)
                begin
                    valid       = 1'b1;
                    lto_next    = 1'b1;
                    lwidth_next = '0;
                    led_next    = BAR_ALL_ON;
                    phase_next  = PH_PAUSE;
                    timer_next  = '0;
                end
            end
            default:
            begin
                oe         = 1'b1;
                timer_next = tmr_inc;
                if (PT_W'(tmr_inc) >= PT_W'(cfg.pause_length) || tmr_inc == '1)
                begin
                    phase_next = PH_SETTLE;
                    timer_next = '0;
                end
            end
        endcase

        lw_ext                = CMP_W'(lwidth_next);
        res.pin_drive         = drive;
        res.pin_output_enable = oe;
        res.led_bar_n         = led_next;
        res.sample_valid      = valid;
        res.pulse_width_us    = (lw_ext > CMP_W'(16'hFFFF)) ? 16'hFFFF : lw_ext[15:0];
        res.timed_out         = lto_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SETTLE;
            timer_reg  <= '0;
            wcnt_reg   <= '0;
            led_reg    <= BAR_ALL_ON;
            lwidth_reg <= '0;
            lto_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            wcnt_reg   <= wcnt_next;
            led_reg    <= led_next;
            lwidth_reg <= lwidth_next;
            lto_reg    <= lto_next;
        end
    end

endmodule

@@ rtl/ultrasonic_ranging_bar_graph.sv @@
// ultrasonic ranging controller with four-led bar graph, top level
// one tick in, one result out; a transferred tick waits in the input register, and the
// result register loads when the sequencer advances on it
// sustains one tick per cycle unless stalled: input register, sequencer, result register
// a stalled result holds the sequencer while the next tick waits in the input register
// reset puts the sequencer in the settle phase with timers cleared, all leds on,
// and the configuration registers at their default values
module ultrasonic_ranging_bar_graph #(
    parameter int TIMER_BITS = uprbg_pkg::TIMER_BITS_DEF,
    parameter int WIDTH_BITS = uprbg_pkg::WIDTH_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [uprbg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uprbg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             echo_level,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             pin_drive,
    output logic                             pin_output_enable,
    output logic [3:0]                       led_bar_n,
    output logic                             sample_valid,
    output logic [15:0]                      pulse_width_us,
    output logic                             timed_out
);
    import uprbg_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t res_reg;

    logic in_vld_reg;
    logic echo_reg;
    logic out_vld_reg;
    logic advance;

    uprbg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uprbg_ctrl #(
        .TIMER_BITS(TIMER_BITS),
        .WIDTH_BITS(WIDTH_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .echo  (echo_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            echo_reg <= echo_level;
        if (advance)
            res_reg <= res;
    end

    assign out_valid         = out_vld_reg;
    assign pin_drive         = res_reg.pin_drive;
    assign pin_output_enable = res_reg.pin_output_enable;
    assign led_bar_n         = res_reg.led_bar_n;
    assign sample_valid      = res_reg.sample_valid;
    assign pulse_width_us    = res_reg.pulse_width_us;
    assign timed_out         = res_reg.timed_out;

endmodule
